// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the bit writer.
// Include by bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msbw_pkg.sv =====
// Shared types and constants of the MSB-first bit writer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msbw_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_NS    = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_COUNT = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam int FIELD_W  = 32;
    localparam int PART_W   = 7;
    localparam int ACC_W    = FIELD_W + PART_W;
    localparam int BL_STEPS = 5;

    typedef struct packed {
        logic       done;
        logic [5:0] width;
    } bl_res_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_NORM   = 8'b0000_0010,
        S_SEL    = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_EMIT   = 8'b0010_0000,
        S_SINGLE = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== design/msbw_bitlen.sv =====
// Iterative bit-length unit: binary search over five shift steps.
// Depends on msbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msbw_bitlen (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [31:0]              n,
    output msbw_pkg::bl_res_t             res
);
    import msbw_pkg::*;

    logic        run_reg, run_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] x_reg, x_next;
    logic [5:0]  w_reg, w_next;
    logic        done_reg, done_next;
    logic [5:0]  amt;
    logic [31:0] upper;

    assign amt   = 6'(6'd16 >> step_reg);
    assign upper = x_reg >> amt;

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        x_next    = x_reg;
        w_next    = w_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = 3'd0;
            x_next    = n;
            w_next    = 6'd0;
        end
        else if (run_reg)
        begin
            if (upper != 32'd0)
            begin
                x_next = upper;
                w_next = w_reg + amt;
            end
            if (step_reg == 3'(BL_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        w_reg <= w_next;
    end

    assign res.done  = done_reg;
    assign res.width = w_reg + 6'd1;

endmodule

`default_nettype wire

// ===== design/msb_first_bit_writer_ns.sv =====
// MSB-first bit writer with truncated binary (ns) code.
// Input item: command on s_tuser; bit_count, value, ns_range on s_tdata.
// Result items: one byte per m_ item; tuser carries byte_valid and status,
// tlast marks the final result of an input item.
// An item is taken only in idle; s_tready is low until its results are queued.
// Write: S_SHIFT and S_LOAD align, then one byte per cycle (up to four bytes).
// ns code: msbw_bitlen finds the bit length in S_NORM, S_SEL then picks the code.
// Flush: one byte if bits are pending. Errors and no-byte items give one result.
// A stalled receiver holds up each byte and result, since each waits for the
// single output register to free up.
// Reset clears pending bits and count and drops any queued result.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module msb_first_bit_writer_ns #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // bit_count[5:0], value[37:6], ns_range[69:38]
    input  wire logic [1:0]  s_tuser,  // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // data_byte[7:0]
    output logic [2:0]       m_tuser,  // byte_valid[0], status[2:1]
    output logic             m_tlast
);
    import msbw_pkg::*;

    state_t               state_reg, state_next;
    logic [FIELD_W-1:0]   val_reg, val_next;
    logic [FIELD_W-1:0]   n_reg, n_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [1:0]           status_reg, status_next;
    logic [FIELD_W:0]     m_reg, m_next;
    logic [5:0]           wl_reg, wl_next;
    logic [FIELD_W-1:0]   vtop_reg, vtop_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [5:0]           total_reg, total_next;
    logic [PART_W-1:0]    pbits_reg, pbits_next;
    logic [2:0]           pcnt_reg, pcnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_bv_reg, out_bv_next;
    logic [1:0]           out_stat_reg, out_stat_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free;

    cmd_t                 in_cmd;
    logic [5:0]           in_count;
    logic [FIELD_W-1:0]   in_value;
    logic [FIELD_W-1:0]   in_range;
    logic                 accept;
    logic                 bl_start;
    bl_res_t              bl_res;
    logic [PART_W-1:0]    ptop;
    logic [ACC_W-1:0]     acc_sh;
    logic [2:0]           tot_rem;
    logic [5:0]           max_bits;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_count = s_tdata[5:0];
    assign in_value = s_tdata[37:6];
    assign in_range = s_tdata[69:38];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign max_bits = 6'(MAX_FIELD_BITS);
    assign bl_start = accept && (in_cmd == CMD_NS) && (in_range != 32'd0)
                      && (in_value < in_range);
    assign ptop     = pbits_reg << (3'd7 - pcnt_reg);
    assign acc_sh   = acc_reg << 8;
    assign tot_rem  = 3'(total_reg - 6'd8);

    msbw_bitlen u_bitlen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bl_start),
        .n     (in_range),
        .res   (bl_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        m_next         = m_reg;
        wl_next        = wl_reg;
        vtop_next      = vtop_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        pbits_next     = pbits_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = (out_valid_reg && !m_tready);
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_WRITE:
                        begin
                            if (in_count > max_bits)
                            begin
                                status_next = STAT_COUNT;
                                state_next  = S_SINGLE;
                            end
                            else
                            begin
                                cnt_next   = in_count;
                                val_next   = in_value;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_NS:
                        begin
                            if (bl_start)
                            begin
                                val_next   = in_value;
                                n_next     = in_range;
                                state_next = S_NORM;
                            end
                            else
                            begin
                                status_next = STAT_RANGE;
                                state_next  = S_SINGLE;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (pcnt_reg == 3'd0)
                            begin
                                status_next = STAT_OK;
                                state_next  = S_SINGLE;
                            end
                            else
                            begin
                                acc_next   = {ptop, {FIELD_W{1'b0}}};
                                total_next = 6'd8;
                                state_next = S_EMIT;
                            end
                        end
                        CMD_RSVD:
                        begin
                            status_next = STAT_OK;
                            state_next  = S_SINGLE;
                        end
                    endcase
                end
            end
            S_NORM:
            begin
                if (bl_res.done)
                begin
                    wl_next    = bl_res.width;
                    m_next     = (33'd1 << bl_res.width) - {1'b0, n_reg};
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if ({1'b0, val_reg} < m_reg)
                begin
                    if ((wl_reg - 6'd1) > max_bits)
                    begin
                        status_next = STAT_COUNT;
                        state_next  = S_SINGLE;
                    end
                    else
                    begin
                        cnt_next   = wl_reg - 6'd1;
                        state_next = S_SHIFT;
                    end
                end
                else if (wl_reg > max_bits)
                begin
                    status_next = STAT_COUNT;
                    state_next  = S_SINGLE;
                end
                else
                begin
                    cnt_next   = wl_reg;
                    val_next   = val_reg + m_reg[FIELD_W-1:0];
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                vtop_next  = val_reg << (6'd32 - cnt_reg);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                acc_next   = {ptop, {FIELD_W{1'b0}}} | ({vtop_reg, {PART_W{1'b0}}} >> pcnt_reg);
                total_next = {3'd0, pcnt_reg} + cnt_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (total_reg < 6'd8)
                begin
                    pcnt_next   = total_reg[2:0];
                    pbits_next  = acc_reg[ACC_W-1:FIELD_W] >> (3'd7 - total_reg[2:0]);
                    status_next = STAT_OK;
                    state_next  = S_SINGLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = acc_reg[ACC_W-1:ACC_W-8];
                    out_bv_next    = 1'b1;
                    out_stat_next  = STAT_OK;
                    out_last_next  = (total_reg < 6'd16);
                    acc_next       = acc_sh;
                    total_next     = total_reg - 6'd8;
                    if (total_reg < 6'd16)
                    begin
                        pcnt_next  = tot_rem;
                        pbits_next = acc_sh[ACC_W-1:FIELD_W] >> (3'd7 - tot_rem);
                        state_next = S_IDLE;
                    end
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    out_bv_next    = 1'b0;
                    out_stat_next  = status_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pbits_reg     <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pbits_reg     <= pbits_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        m_reg        <= m_next;
        wl_reg       <= wl_next;
        vtop_reg     <= vtop_next;
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_stat_reg, out_bv_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPLIES(a_part_clean, clk, rst_n, 1'b1, ((pbits_reg >> pcnt_reg) == 7'd0), "pending bits above count")
    `ASSERT_IMPLIES(a_nobyte_last, clk, rst_n, m_tvalid && !m_tuser[0], m_tlast, "no-byte result not last")
    `ASSERT_IMPLIES(a_err_nobyte, clk, rst_n, m_tvalid && (m_tuser[2:1] != STAT_OK), !m_tuser[0], "error result carries byte")
    `ASSERT_IMPLIES(a_total_range, clk, rst_n, state_reg == S_EMIT, total_reg <= 6'(ACC_W), "bit total out of range")

endmodule

`default_nettype wire

// ===== test/msbw_byte_checker.sv =====
// Byte stream checker for the MSB-first bit writer: predicts the output bytes
// from every accepted command item and compares each accepted result item.
// Depends on msbw_pkg for command codes and status values.
`timescale 1ns / 1ps

module msbw_byte_checker #(
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import msbw_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] stat;
        logic       last;
    } byte_item_t;

    byte_item_t exp_bytes[$];
    logic [6:0] pend_bits = '0;
    logic [2:0] pend_cnt  = '0;
    int         err_cnt   = 0;

    task automatic push_single(input logic [1:0] stat);
        byte_item_t r;
        r.data  = 8'd0;
        r.valid = 1'b0;
        r.stat  = stat;
        r.last  = 1'b1;
        exp_bytes.push_back(r);
    endtask

    // append the low cnt bits of val behind the pending bits
    task automatic pack_field(input int unsigned cnt, input logic [63:0] val);
        logic [63:0] mask;
        logic [63:0] acc;
        logic [63:0] shifted;
        int unsigned total;
        byte_item_t  r;
        mask  = (64'd1 << cnt) - 64'd1;
        acc   = ({57'd0, pend_bits} << cnt) | (val & mask);
        total = pend_cnt + cnt;
        if (total < 8)
            push_single(STAT_OK);
        while (total >= 8)
        begin
            shifted = acc >> (total - 8);
            r.data  = shifted[7:0];
            r.valid = 1'b1;
            r.stat  = STAT_OK;
            r.last  = (total < 16);
            exp_bytes.push_back(r);
            total -= 8;
        end
        pend_cnt = total[2:0];
        shifted  = acc & ((64'd1 << pend_cnt) - 64'd1);
        pend_bits = shifted[6:0];
    endtask

    task automatic predict_command(input logic [1:0] cmd, input logic [71:0] d);
        logic [5:0]  cnt;
        logic [32:0] v33;
        logic [32:0] n33;
        logic [32:0] m33;
        logic [7:0]  b;
        int unsigned w;
        byte_item_t  r;
        cnt = d[5:0];
        v33 = {1'b0, d[37:6]};
        n33 = {1'b0, d[69:38]};
        case (cmd)
            CMD_WRITE:
            begin
                if (cnt > MAX_FIELD_BITS)
                    push_single(STAT_COUNT);
                else
                    pack_field(cnt, {32'd0, d[37:6]});
            end
            CMD_NS:
            begin
                if (n33 == 33'd0 || v33 >= n33)
                begin
                    push_single(STAT_RANGE);
                end
                else
                begin
                    w = 0;
                    for (int i = 0; i < 32; i++)
                        if (n33[i])
                            w = i + 1;
                    m33 = (33'd1 << w) - n33;
                    if (v33 < m33)
                    begin
                        if (w - 1 > MAX_FIELD_BITS)
                            push_single(STAT_COUNT);
                        else
                            pack_field(w - 1, {31'd0, v33});
                    end
                    else if (w > MAX_FIELD_BITS)
                    begin
                        push_single(STAT_COUNT);
                    end
                    else
                    begin
                        pack_field(w, {31'd0, v33 + m33});
                    end
                end
            end
            CMD_FLUSH:
            begin
                if (pend_cnt == 3'd0)
                begin
                    pend_bits = '0;
                    push_single(STAT_OK);
                end
                else
                begin
                    b = {1'b0, pend_bits} << (4'd8 - pend_cnt);
                    r.data  = b;
                    r.valid = 1'b1;
                    r.stat  = STAT_OK;
                    r.last  = 1'b1;
                    exp_bytes.push_back(r);
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default: push_single(STAT_OK);
        endcase
    endtask

    always @(posedge clk)
    begin : monitor
        byte_item_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result: data %h user %b last %b", $time,
                             m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    e = exp_bytes.pop_front();
                    if (m_tdata !== e.data)
                    begin
                        err_cnt++;
                        $display("%0t: data_byte expected %h actual %h", $time,
                                 e.data, m_tdata);
                    end
                    if (m_tuser[0] !== e.valid)
                    begin
                        err_cnt++;
                        $display("%0t: byte_valid expected %b actual %b", $time,
                                 e.valid, m_tuser[0]);
                    end
                    if (m_tuser[2:1] !== e.stat)
                    begin
                        err_cnt++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 e.stat, m_tuser[2:1]);
                    end
                    if (m_tlast !== e.last)
                    begin
                        err_cnt++;
                        $display("%0t: last expected %b actual %b", $time,
                                 e.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata);
        end
        errors  <= err_cnt;
        pending <= exp_bytes.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the bit writer testbench: clock, reset, command stimulus and
// receiver stalls; msbw_byte_checker does prediction and comparison.
// Depends on msbw_pkg, msb_first_bit_writer_ns and msbw_byte_checker.
`timescale 1ns / 1ps

module tb_top;
    import msbw_pkg::*;

    localparam int N_RANDOM   = 320;
    localparam int DRAIN_CYC  = 40;
    localparam int CYCLE_MAX  = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          cycle_cnt = 0;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;

    msb_first_bit_writer_ns uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    msbw_byte_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt == CYCLE_MAX);
        $display("** msb_first_bit_writer_ns: FAILED **");
        $finish;
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_cmd(input cmd_t cmd, input logic [5:0] cnt,
                            input logic [31:0] val, input logic [31:0] rng);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, rng, val, cnt};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // receiver: random stall before each result item
    initial
    begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] rng;
        logic [31:0] val;
        int          len;
        int          pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_cmd(CMD_WRITE, 6'd0, $urandom, $urandom);
        send_cmd(CMD_FLUSH, 6'($urandom), $urandom, $urandom);
        send_cmd(CMD_WRITE, 6'd32, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_WRITE, 6'd3, 32'h0000_0005, 32'hFFFF_FFFF);
        send_cmd(CMD_WRITE, 6'd32, 32'hA5A5_5A5A, 32'h0);
        send_cmd(CMD_FLUSH, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_WRITE, 6'd33, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_WRITE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_WRITE, 6'd7, 32'h0000_007F, 32'h0);
        send_cmd(CMD_WRITE, 6'd32, 32'h0000_0000, 32'h0);
        send_cmd(CMD_RSVD, 6'($urandom), $urandom, $urandom);
        send_cmd(CMD_FLUSH, 6'd0, 32'h0, 32'h0);
        send_cmd(CMD_NS, 6'($urandom), 32'd3, 32'd0);
        send_cmd(CMD_NS, 6'($urandom), 32'd5, 32'd5);
        send_cmd(CMD_NS, 6'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_NS, 6'($urandom), 32'd0, 32'd1);
        send_cmd(CMD_NS, 6'($urandom), 32'd1, 32'd5);
        send_cmd(CMD_NS, 6'($urandom), 32'd4, 32'd5);
        send_cmd(CMD_NS, 6'($urandom), 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_cmd(CMD_NS, 6'($urandom), 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(CMD_NS, 6'($urandom), 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(CMD_RSVD, 6'($urandom), $urandom, $urandom);
        send_cmd(CMD_FLUSH, 6'($urandom), $urandom, $urandom);

        // random part
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_cmd(CMD_WRITE, 6'($urandom_range(0, 32)), $urandom, $urandom);
            end
            else if (pick < 46)
            begin
                send_cmd(CMD_WRITE, 6'($urandom_range(33, 63)), $urandom, $urandom);
            end
            else if (pick < 80)
            begin
                len = $urandom_range(1, 32);
                rng = $urandom;
                if (len < 32)
                    rng = rng & ((32'd1 << len) - 32'd1);
                rng[len - 1] = 1'b1;
                val = $urandom % rng;
                send_cmd(CMD_NS, 6'($urandom), val, rng);
            end
            else if (pick < 87)
            begin
                a = $urandom;
                b = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
                if ($urandom_range(0, 3) == 0)
                    b = a;
                if (a >= b)
                    send_cmd(CMD_NS, 6'($urandom), a, b);
                else
                    send_cmd(CMD_NS, 6'($urandom), b, a);
            end
            else if (pick < 96)
            begin
                send_cmd(CMD_FLUSH, 6'($urandom), $urandom, $urandom);
            end
            else
            begin
                send_cmd(CMD_RSVD, 6'($urandom), $urandom, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** msb_first_bit_writer_ns: PASSED **");
        else
            $display("** msb_first_bit_writer_ns: FAILED **");
        $finish;
    end

endmodule
